// ===== rtl/core/utnorm_pkg.sv =====
// shared types, constants and folding functions for the utf-8 text normalizer
`timescale 1ns / 1ps
package utnorm_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [6:0]  CH_SPACE        = 7'h20;
  localparam logic [20:0] CP_ASCII_END    = 21'h000080;
  localparam logic [20:0] CP_TWO_MIN      = 21'h000800;
  localparam logic [20:0] CP_FOUR_MIN     = 21'h010000;
  localparam logic [20:0] CP_MAX          = 21'h10FFFF;
  localparam logic [20:0] CP_SURR_LO      = 21'h00D800;
  localparam logic [20:0] CP_SURR_HI      = 21'h00DFFF;
  localparam logic [20:0] CP_FW_LO        = 21'h00FF01;
  localparam logic [20:0] CP_FW_HI        = 21'h00FF5E;
  localparam logic [20:0] CP_LAT_LO       = 21'h0000C0;
  localparam logic [20:0] CP_LAT_HI       = 21'h0000FF;
  localparam logic [6:0]  FW_OFFSET       = 7'h20;

  localparam logic [2:0] SEQ_NONE = 3'd0;
  localparam logic [2:0] SEQ_TWO  = 3'd2;
  localparam logic [2:0] SEQ_THREE = 3'd3;
  localparam logic [2:0] SEQ_FOUR = 3'd4;

  // one decoded byte as work for the run stage
  typedef struct packed {
    logic [2:0] nsp;
    logic       has_char;
    logic [6:0] ch;
    logic       eom;
  } utn_cmd_t;

  function automatic logic [6:0] lower7(input logic [6:0] c);
    lower7 = (c >= 7'h41 && c <= 7'h5A) ? c + 7'h20 : c;
  endfunction

  function automatic logic [6:0] latin_fold(input logic [5:0] idx);
    logic [6:0] r;
    unique case (idx[4:0]) inside
      [5'd0:5'd5]:             r = 7'h61;
      5'd7:                    r = 7'h63;
      [5'd8:5'd11]:            r = 7'h65;
      [5'd12:5'd15]:           r = 7'h69;
      5'd17:                   r = 7'h6E;
      [5'd18:5'd22], 5'd24:    r = 7'h6F;
      [5'd25:5'd28]:           r = 7'h75;
      5'd29:                   r = 7'h79;
      5'd31:                   r = idx[5] ? 7'h79 : 7'h00;
      default:                 r = 7'h00;
    endcase
    latin_fold = r;
  endfunction

  function automatic logic is_dropped(input logic [20:0] cp);
    is_dropped = (cp >= 21'h000300 && cp <= 21'h00036F) ||
                 (cp >= 21'h0020D0 && cp <= 21'h0020FF) ||
                 (cp >= 21'h00FE20 && cp <= 21'h00FE2F) ||
                 (cp >= 21'h001AB0 && cp <= 21'h001AFF) ||
                 (cp >= 21'h001DC0 && cp <= 21'h001DFF) ||
                 cp == 21'h00200B || cp == 21'h00200C || cp == 21'h00200D ||
                 cp == 21'h002060 || cp == 21'h00FEFF || cp == 21'h00180E ||
                 cp == 21'h0000AD;
  endfunction

  // zero means no mapping
  function automatic logic [6:0] fold_other(input logic [20:0] cp);
    logic [6:0] r;
    if (cp >= CP_FW_LO && cp <= CP_FW_HI) begin
      r = lower7(cp[6:0] + FW_OFFSET);
    end else if (cp >= CP_LAT_LO && cp <= CP_LAT_HI) begin
      r = latin_fold(cp[5:0]);
    end else begin
      unique case (cp) inside
        21'h000430, 21'h000410, 21'h0003B1: r = 7'h61;
        21'h000435, 21'h000415, 21'h0003B5: r = 7'h65;
        21'h000456, 21'h0003B9:             r = 7'h69;
        21'h00043E, 21'h00041E, 21'h0003BF: r = 7'h6F;
        21'h000440, 21'h000420, 21'h0003C1: r = 7'h70;
        21'h000441, 21'h000421:             r = 7'h63;
        21'h000443:                         r = 7'h79;
        21'h000445, 21'h000425, 21'h0003C7: r = 7'h78;
        21'h00043A, 21'h00041A, 21'h0003BA: r = 7'h6B;
        21'h00043C, 21'h00041C:             r = 7'h6D;
        21'h000412:                         r = 7'h62;
        21'h00041D:                         r = 7'h68;
        21'h000422:                         r = 7'h74;
        21'h0003BD:                         r = 7'h76;
        default:                            r = 7'h00;
      endcase
    end
    fold_other = r;
  endfunction

  // {keep, char}
  function automatic logic [7:0] fold_code(input logic [20:0] cp);
    logic [6:0] c;
    logic [7:0] r;
    if (is_dropped(cp)) begin
      r = 8'h00;
    end else if (cp < CP_ASCII_END) begin
      c = lower7(cp[6:0]);
      unique case (c)
        7'h30:   c = 7'h6F;
        7'h31:   c = 7'h69;
        7'h33:   c = 7'h65;
        7'h34:   c = 7'h61;
        7'h35:   c = 7'h73;
        7'h37:   c = 7'h74;
        7'h39:   c = 7'h67;
        default: c = c;
      endcase
      r = {1'b1, c};
    end else begin
      c = fold_other(cp);
      r = {1'b1, (c != 7'h00) ? c : CH_SPACE};
    end
    fold_code = r;
  endfunction

endpackage

// ===== rtl/core/utnorm_front.sv =====
// front end: utf-8 sequence decoder and character classifier
`timescale 1ns / 1ps
module utnorm_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [7:0]          in_byte,
  input  logic                in_end_of_message,
  output logic                push,
  output utnorm_pkg::utn_cmd_t cmd
);
  import utnorm_pkg::*;

  logic [20:0] partial_r, partial_nxt;
  logic [2:0]  seq_w_r, seq_w_nxt;
  logic [1:0]  held_r, held_nxt;

  logic        in_seq, is_cont, bad, opened;
  logic [2:0]  held_inc;
  logic [20:0] pc_ext, cp_sel;
  logic [7:0]  fc;

  assign in_seq   = (seq_w_r != SEQ_NONE);
  assign is_cont  = (in_byte[7:6] == 2'b10);
  assign held_inc = {1'b0, held_r} + 3'd1;
  assign pc_ext   = {partial_r[14:0], in_byte[5:0]};
  assign cp_sel   = (in_seq && is_cont) ? pc_ext : {13'd0, in_byte};
  assign fc       = fold_code(cp_sel);
  assign bad      = (pc_ext >= CP_SURR_LO && pc_ext <= CP_SURR_HI) || pc_ext > CP_MAX ||
                    (seq_w_r == SEQ_TWO && pc_ext < CP_ASCII_END) ||
                    (seq_w_r == SEQ_THREE && pc_ext < CP_TWO_MIN) ||
                    (seq_w_r == SEQ_FOUR && pc_ext < CP_FOUR_MIN);

  always_comb begin
    cmd         = '0;
    cmd.eom     = in_end_of_message;
    partial_nxt = partial_r;
    seq_w_nxt   = seq_w_r;
    held_nxt    = held_r;
    opened      = 1'b0;
    if (in_seq && is_cont) begin
      if (held_inc >= seq_w_r) begin
        partial_nxt = '0;
        seq_w_nxt   = SEQ_NONE;
        held_nxt    = '0;
        if (bad) begin
          cmd.nsp = seq_w_r;
        end else begin
          cmd.has_char = fc[7];
          cmd.ch       = fc[6:0];
        end
      end else begin
        partial_nxt = pc_ext;
        held_nxt    = held_inc[1:0];
        if (in_end_of_message) begin
          cmd.nsp     = held_inc;
          partial_nxt = '0;
          seq_w_nxt   = SEQ_NONE;
          held_nxt    = '0;
        end
      end
    end else begin
      cmd.nsp     = in_seq ? {1'b0, held_r} : 3'd0;
      partial_nxt = '0;
      seq_w_nxt   = SEQ_NONE;
      held_nxt    = '0;
      if (!in_byte[7]) begin
        cmd.has_char = fc[7];
        cmd.ch       = fc[6:0];
      end else if (in_byte[7:5] == 3'b110) begin
        partial_nxt = {16'd0, in_byte[4:0]};
        seq_w_nxt   = SEQ_TWO;
        held_nxt    = 2'd1;
        opened      = 1'b1;
      end else if (in_byte[7:4] == 4'b1110) begin
        partial_nxt = {17'd0, in_byte[3:0]};
        seq_w_nxt   = SEQ_THREE;
        held_nxt    = 2'd1;
        opened      = 1'b1;
      end else if (in_byte[7:3] == 5'b11110) begin
        partial_nxt = {18'd0, in_byte[2:0]};
        seq_w_nxt   = SEQ_FOUR;
        held_nxt    = 2'd1;
        opened      = 1'b1;
      end else begin
        cmd.has_char = 1'b1;
        cmd.ch       = CH_SPACE;
      end
      if (opened && in_end_of_message) begin
        cmd.nsp     = cmd.nsp + 3'd1;
        partial_nxt = '0;
        seq_w_nxt   = SEQ_NONE;
        held_nxt    = '0;
      end
    end
  end

  assign push = accept && (cmd.nsp != 3'd0 || cmd.has_char || cmd.eom);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= '0;
      seq_w_r   <= SEQ_NONE;
      held_r    <= '0;
    end else if (accept) begin
      partial_r <= partial_nxt;
      seq_w_r   <= seq_w_nxt;
      held_r    <= held_nxt;
    end
  end

endmodule

// ===== rtl/core/utnorm_fifo.sv =====
// short request queue between decoder and run stage
`timescale 1ns / 1ps
module utnorm_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  utnorm_pkg::utn_cmd_t wr_cmd,
  input  logic                 pop,
  output logic                 full,
  output logic                 head_valid,
  output utnorm_pkg::utn_cmd_t head_cmd
);
  import utnorm_pkg::*;

  utn_cmd_t         mem_r [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QAW:0]     count_r, count_nxt;
  logic             do_pop;

  assign full       = (count_r == (QAW+1)'(QDEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = mem_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  always_comb begin
    count_nxt = count_r;
    if (push && !do_pop) count_nxt = count_r + 1'b1;
    else if (!push && do_pop) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wr_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

endmodule

// ===== rtl/core/utnorm_back.sv =====
// back end: run collapsing, end markers and output register
`timescale 1ns / 1ps
module utnorm_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 head_valid,
  input  utnorm_pkg::utn_cmd_t head_cmd,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [6:0]           out_char,
  output logic                 out_end_marker
);
  import utnorm_pkg::*;

  logic [2:0] sp_cnt_r, sp_cnt_nxt;
  logic       chr_done_r, chr_done_nxt;
  logic [6:0] run_char_r, run_char_nxt;
  logic [1:0] run_len_r, run_len_nxt;
  logic       out_valid_r;
  logic [6:0] out_char_r;
  logic       out_mark_r;

  logic       out_free, step, sp_pend, ch_pend, feeding, last_feed, is_letter;
  logic [6:0] feed_c;
  logic       emit, emit_mark;
  logic [6:0] emit_c;

  assign out_free  = !out_valid_r || out_ready;
  assign step      = head_valid && out_free;
  assign sp_pend   = (sp_cnt_r < head_cmd.nsp);
  assign ch_pend   = head_cmd.has_char && !chr_done_r;
  assign feeding   = sp_pend || ch_pend;
  assign feed_c    = sp_pend ? CH_SPACE : head_cmd.ch;
  assign last_feed = sp_pend ? ((sp_cnt_r + 3'd1 == head_cmd.nsp) && !head_cmd.has_char)
                             : 1'b1;
  assign is_letter = (feed_c >= 7'h61 && feed_c <= 7'h7A);

  always_comb begin
    sp_cnt_nxt   = sp_cnt_r;
    chr_done_nxt = chr_done_r;
    run_char_nxt = run_char_r;
    run_len_nxt  = run_len_r;
    emit         = 1'b0;
    emit_mark    = 1'b0;
    emit_c       = 7'h00;
    pop          = 1'b0;
    if (step) begin
      if (feeding) begin
        if (is_letter && run_len_r != 2'd0 && run_char_r == feed_c) begin
          if (run_len_r != 2'd3) run_len_nxt = run_len_r + 2'd1;
          if (sp_pend) sp_cnt_nxt = sp_cnt_r + 3'd1;
          else chr_done_nxt = 1'b1;
          if (last_feed && !head_cmd.eom) pop = 1'b1;
        end else if (run_len_r == 2'd2) begin
          // release the held second letter first
          emit         = 1'b1;
          emit_c       = run_char_r;
          run_char_nxt = 7'h00;
          run_len_nxt  = 2'd0;
        end else begin
          emit         = 1'b1;
          emit_c       = feed_c;
          run_char_nxt = is_letter ? feed_c : 7'h00;
          run_len_nxt  = is_letter ? 2'd1 : 2'd0;
          if (sp_pend) sp_cnt_nxt = sp_cnt_r + 3'd1;
          else chr_done_nxt = 1'b1;
          if (last_feed && !head_cmd.eom) pop = 1'b1;
        end
      end else if (head_cmd.eom) begin
        emit         = 1'b1;
        run_char_nxt = 7'h00;
        run_len_nxt  = 2'd0;
        if (run_len_r == 2'd2) begin
          emit_c = run_char_r;
        end else begin
          emit_mark = 1'b1;
          pop       = 1'b1;
        end
      end else begin
        pop = 1'b1;
      end
      if (pop) begin
        sp_cnt_nxt   = 3'd0;
        chr_done_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_cnt_r    <= '0;
      chr_done_r  <= 1'b0;
      run_char_r  <= '0;
      run_len_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      sp_cnt_r   <= sp_cnt_nxt;
      chr_done_r <= chr_done_nxt;
      run_char_r <= run_char_nxt;
      run_len_r  <= run_len_nxt;
      if (emit) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_char_r <= emit_c;
      out_mark_r <= emit_mark;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_char       = out_char_r;
  assign out_end_marker = out_mark_r;

endmodule

// ===== rtl/core/utf8_text_normalizer_top.sv =====
// top level of the utf-8 text normalizer
//
//   channel | ports                                     | direction
//   --------+-------------------------------------------+----------
//   input   | in_valid, in_ready, in_byte,              | in
//           | in_end_of_message                         |
//   result  | out_valid, out_ready, out_char,           | out
//           | out_end_marker                            |
//
// one byte accepted per cycle while the four-entry queue has room
// the run stage emits its results one at a time into the output register; a byte gives up to six results
// so a burst of spaces or a message end slows intake until the queue drains
// input stalls only on a full queue, results wait in one output register
// synchronous active-low reset clears decoder, queue, run state and output
`timescale 1ns / 1ps
module utf8_text_normalizer_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_message,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [6:0] out_char,
  output logic       out_end_marker
);
  import utnorm_pkg::*;

  logic     accept, push, pop, full, head_valid;
  utn_cmd_t wr_cmd, head_cmd;

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;

  utnorm_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .accept            (accept),
    .in_byte           (in_byte),
    .in_end_of_message (in_end_of_message),
    .push              (push),
    .cmd               (wr_cmd)
  );

  utnorm_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .wr_cmd     (wr_cmd),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  utnorm_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_valid     (head_valid),
    .head_cmd       (head_cmd),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_char       (out_char),
    .out_end_marker (out_end_marker)
  );

endmodule

// ===== test/utnorm_checker.sv =====
`timescale 1ns / 1ps
// checker for the utf-8 text normalizer: predicts the characters of each request and compares
module utnorm_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_message,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [6:0] out_char,
  input  logic       out_end_marker,
  output int         fail_count,
  output int         outstanding
);

  localparam int         MAX_PER_REQUEST = 6;
  localparam logic [6:0] CHAR_NUL        = 7'h00;
  localparam logic [6:0] CHAR_SPACE      = 7'h20;
  localparam logic [6:0] CHAR_A          = 7'h61;
  localparam logic [6:0] CHAR_Z          = 7'h7A;

  typedef struct packed {
    logic [6:0] ch;
    logic       marker;
  } norm_char_t;

  logic [20:0] code_acc;
  logic [2:0]  seq_len;
  logic [1:0]  seq_got;
  logic [6:0]  run_letter;
  logic [1:0]  run_count;
  int          step_results;
  norm_char_t  expected_chars[$];

  task automatic add_expected(input logic [6:0] c, input logic m);
    if (step_results < MAX_PER_REQUEST) begin
      expected_chars.insert(expected_chars.size(), norm_char_t'({c, m}));
      step_results++;
    end
  endtask

  // a held second letter goes out when its run ends
  task automatic end_run();
    if (run_count == 2'd2) add_expected(run_letter, 1'b0);
    run_letter = '0;
    run_count  = '0;
  endtask

  task automatic collapse_char(input logic [6:0] c);
    if (c >= CHAR_A && c <= CHAR_Z) begin
      if (run_count != 2'd0 && run_letter == c) begin
        if (run_count < 2'd3) run_count = run_count + 2'd1;
      end else begin
        end_run();
        add_expected(c, 1'b0);
        run_letter = c;
        run_count  = 2'd1;
      end
    end else begin
      end_run();
      add_expected(c, 1'b0);
    end
  endtask

  task automatic add_spaces(input int k);
    for (int j = 0; j < k; j++) collapse_char(CHAR_SPACE);
  endtask

  function automatic logic [6:0] to_lower(input logic [6:0] c);
    return (c >= 7'h41 && c <= 7'h5A) ? c + 7'h20 : c;
  endfunction

  function automatic logic is_invisible(input logic [20:0] cp);
    return (cp >= 21'h000300 && cp <= 21'h00036F) ||
           (cp >= 21'h0020D0 && cp <= 21'h0020FF) ||
           (cp >= 21'h00FE20 && cp <= 21'h00FE2F) ||
           (cp >= 21'h001AB0 && cp <= 21'h001AFF) ||
           (cp >= 21'h001DC0 && cp <= 21'h001DFF) ||
           cp == 21'h00200B || cp == 21'h00200C || cp == 21'h00200D ||
           cp == 21'h002060 || cp == 21'h00FEFF || cp == 21'h00180E ||
           cp == 21'h0000AD;
  endfunction

  function automatic logic [6:0] latin1_letter(input logic [5:0] idx);
    logic [4:0] k;
    k = idx[4:0];
    if (k <= 5'd5) return 7'h61;
    if (k == 5'd7) return 7'h63;
    if (k >= 5'd8 && k <= 5'd11) return 7'h65;
    if (k >= 5'd12 && k <= 5'd15) return 7'h69;
    if (k == 5'd17) return 7'h6E;
    if ((k >= 5'd18 && k <= 5'd22) || k == 5'd24) return 7'h6F;
    if (k >= 5'd25 && k <= 5'd28) return 7'h75;
    if (k == 5'd29 || (k == 5'd31 && idx[5])) return 7'h79;
    return CHAR_NUL;
  endfunction

  // zero when the code point has no ascii look-alike
  function automatic logic [6:0] lookalike(input logic [20:0] cp);
    logic [20:0] shifted;
    shifted = cp - 21'h00FEE0;
    if (cp >= 21'h00FF01 && cp <= 21'h00FF5E) return to_lower(shifted[6:0]);
    if (cp >= 21'h0000C0 && cp <= 21'h0000FF) return latin1_letter(cp[5:0]);
    case (cp)
      21'h000430, 21'h000410, 21'h0003B1: return 7'h61;
      21'h000435, 21'h000415, 21'h0003B5: return 7'h65;
      21'h000456, 21'h0003B9:             return 7'h69;
      21'h00043E, 21'h00041E, 21'h0003BF: return 7'h6F;
      21'h000440, 21'h000420, 21'h0003C1: return 7'h70;
      21'h000441, 21'h000421:             return 7'h63;
      21'h000443:                         return 7'h79;
      21'h000445, 21'h000425, 21'h0003C7: return 7'h78;
      21'h00043A, 21'h00041A, 21'h0003BA: return 7'h6B;
      21'h00043C, 21'h00041C:             return 7'h6D;
      21'h000412:                         return 7'h62;
      21'h00041D:                         return 7'h68;
      21'h000422:                         return 7'h74;
      21'h0003BD:                         return 7'h76;
      default:                            return CHAR_NUL;
    endcase
  endfunction

  task automatic emit_point(input logic [20:0] cp);
    logic [6:0] c;
    if (is_invisible(cp)) return;
    if (cp < 21'h000080) begin
      c = to_lower(cp[6:0]);
      case (c)
        7'h30:   c = 7'h6F;
        7'h31:   c = 7'h69;
        7'h33:   c = 7'h65;
        7'h34:   c = 7'h61;
        7'h35:   c = 7'h73;
        7'h37:   c = 7'h74;
        7'h39:   c = 7'h67;
        default: c = c;
      endcase
      collapse_char(c);
    end else begin
      c = lookalike(cp);
      collapse_char(c != CHAR_NUL ? c : CHAR_SPACE);
    end
  endtask

  task automatic clear_seq();
    code_acc = '0;
    seq_len  = '0;
    seq_got  = '0;
  endtask

  task automatic drop_seq();
    int k;
    k = int'(seq_got);
    clear_seq();
    add_spaces(k);
  endtask

  task automatic open_seq(input logic [7:0] b);
    if (b < 8'h80) begin
      emit_point({13'd0, b});
    end else if (b[7:5] == 3'b110) begin
      code_acc = {16'd0, b[4:0]};
      seq_len  = 3'd2;
      seq_got  = 2'd1;
    end else if (b[7:4] == 4'b1110) begin
      code_acc = {17'd0, b[3:0]};
      seq_len  = 3'd3;
      seq_got  = 2'd1;
    end else if (b[7:3] == 5'b11110) begin
      code_acc = {18'd0, b[2:0]};
      seq_len  = 3'd4;
      seq_got  = 2'd1;
    end else begin
      collapse_char(CHAR_SPACE);
    end
  endtask

  task automatic close_seq();
    logic [20:0] cp;
    logic [2:0]  w;
    logic        bad;
    cp  = code_acc;
    w   = seq_len;
    bad = (cp >= 21'h00D800 && cp <= 21'h00DFFF) || cp > 21'h10FFFF ||
          (w == 3'd2 && cp < 21'h000080) || (w == 3'd3 && cp < 21'h000800) ||
          (w == 3'd4 && cp < 21'h010000);
    clear_seq();
    if (bad) add_spaces(int'(w));
    else emit_point(cp);
  endtask

  task automatic normalize_byte(input logic [7:0] b, input logic eom);
    step_results = 0;
    if (seq_len != 3'd0 && b[7:6] == 2'b10) begin
      code_acc = {code_acc[14:0], b[5:0]};
      if ({1'b0, seq_got} + 3'd1 >= seq_len) close_seq();
      else seq_got = seq_got + 2'd1;
    end else begin
      if (seq_len != 3'd0) drop_seq();
      open_seq(b);
    end
    if (eom) begin
      if (seq_len != 3'd0) drop_seq();
      end_run();
      add_expected(CHAR_NUL, 1'b1);
    end
  endtask

  always @(posedge clk) begin
    norm_char_t want;
    if (!rst_n) begin
      clear_seq();
      run_letter = '0;
      run_count  = '0;
      expected_chars.delete();
      fail_count = 0;
    end else begin
      if (in_valid && in_ready) normalize_byte(in_byte, in_end_of_message);
      if (out_valid && out_ready) begin
        if (expected_chars.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual char %h marker %b",
                   $time, out_char, out_end_marker);
          fail_count++;
        end else begin
          want = expected_chars.pop_front();
          if (out_char !== want.ch) begin
            $display("%0t: out_char mismatch: expected %h, actual %h",
                     $time, want.ch, out_char);
            fail_count++;
          end
          if (out_end_marker !== want.marker) begin
            $display("%0t: out_end_marker mismatch: expected %b, actual %b",
                     $time, want.marker, out_end_marker);
            fail_count++;
          end
        end
      end
    end
    outstanding = expected_chars.size();
  end

endmodule

// ===== test/utf8_text_normalizer_top_tb.sv =====
`timescale 1ns / 1ps
// testbench top for the utf-8 text normalizer: drives byte requests and output stalls
module utf8_text_normalizer_top_tb;

  localparam int CYCLE_LIMIT    = 200000;
  localparam int DIRECTED_COUNT = 25;
  localparam int RANDOM_TARGET  = 250;
  localparam int LONG_HOLD      = 150;

  // {end_of_message, byte}
  localparam logic [8:0] DIRECTED_SEQ [DIRECTED_COUNT] = '{
    9'h000, 9'h07F, 9'h0FF, 9'h180,
    9'h041, 9'h041, 9'h141,
    9'h0C0, 9'h080,
    9'h0ED, 9'h0A0, 9'h080,
    9'h0F4, 9'h090, 9'h080, 9'h180,
    9'h0E2, 9'h141,
    9'h0CC, 9'h081, 9'h0EF, 9'h0BC, 9'h1A1,
    9'h0F0, 9'h19F
  };

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_PATTERN, RX_SLOW} rx_mode_t;

  logic       clk               = 1'b0;
  logic       rst_n             = 1'b0;
  logic       in_valid          = 1'b0;
  logic [7:0] in_byte           = 8'h00;
  logic       in_end_of_message = 1'b0;
  logic       out_ready         = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic [6:0] out_char;
  logic       out_end_marker;

  logic       in_taken   = 1'b0;
  logic       bulk_phase = 1'b0;
  logic       hold_done  = 1'b0;
  int         fail_count;
  int         outstanding;
  int         cycle_count   = 0;
  int         burst_left    = 0;
  int         requests_sent = 0;
  int         hold_left     = 0;
  int         mode_left     = 0;
  int         pattern_step  = 0;
  rx_mode_t   rx_mode       = RX_OPEN;
  logic [7:0] message_bytes[$];
  logic [20:0] zero_width_codes [6] = '{
    21'h00200B, 21'h00200C, 21'h00200D, 21'h002060, 21'h00FEFF, 21'h00180E
  };

  always #10 clk = ~clk;

  utf8_text_normalizer_top i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_byte           (in_byte),
    .in_end_of_message (in_end_of_message),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_char          (out_char),
    .out_end_marker    (out_end_marker)
  );

  utnorm_checker i_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_byte           (in_byte),
    .in_end_of_message (in_end_of_message),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_char          (out_char),
    .out_end_marker    (out_end_marker),
    .fail_count        (fail_count),
    .outstanding       (outstanding)
  );

  always @(posedge clk) begin
    in_taken    <= in_valid && in_ready;
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver: one long hold once bulk traffic starts, then changing stall patterns
  always @(negedge clk) begin
    if (rst_n) begin
      if (bulk_phase && !hold_done) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready = 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode   = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(10, 80);
        end
        mode_left--;
        case (rx_mode)
          RX_OPEN:    out_ready = 1'b1;
          RX_COIN:    out_ready = 1'($urandom_range(0, 1));
          RX_PATTERN: out_ready = (pattern_step % 5) < 3;
          default:    out_ready = ($urandom_range(0, 3) == 0);
        endcase
        pattern_step++;
      end
    end
  end

  // called at a falling edge, returns at the falling edge after the request is taken
  task automatic offer_byte(input logic [7:0] b, input logic eom);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_valid          = 1'b1;
    in_byte           = b;
    in_end_of_message = eom;
    do @(negedge clk); while (!in_taken);
    burst_left--;
    requests_sent++;
  endtask

  task automatic append_byte(input logic [7:0] b);
    message_bytes.insert(message_bytes.size(), b);
  endtask

  task automatic add_code(input logic [20:0] cp, input int width);
    case (width)
      1: append_byte(cp[7:0]);
      2: begin
        append_byte({3'b110, cp[10:6]});
        append_byte({2'b10, cp[5:0]});
      end
      3: begin
        append_byte({4'b1110, cp[15:12]});
        append_byte({2'b10, cp[11:6]});
        append_byte({2'b10, cp[5:0]});
      end
      default: begin
        append_byte({5'b11110, cp[20:18]});
        append_byte({2'b10, cp[17:12]});
        append_byte({2'b10, cp[11:6]});
        append_byte({2'b10, cp[5:0]});
      end
    endcase
  endtask

  task automatic add_token();
    int          pick;
    int          n;
    int          w;
    int          keep;
    logic [20:0] cp;
    logic [7:0]  letter;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      letter = 8'h61 + 8'($urandom_range(0, 25));
      if ($urandom_range(0, 3) == 0) letter = letter - 8'h20;
      n = $urandom_range(1, 4);
      repeat (n) append_byte(letter);
    end else if (pick < 40) begin
      append_byte(8'($urandom_range(0, 127)));
    end else if (pick < 45) begin
      append_byte(8'h30 + 8'($urandom_range(0, 9)));
    end else if (pick < 60) begin
      case ($urandom_range(0, 5))
        0:       cp = 21'h0000C0 + 21'($urandom_range(0, 63));
        1:       cp = 21'h000400 + 21'($urandom_range(0, 95));
        2:       cp = 21'h000391 + 21'($urandom_range(0, 56));
        3:       cp = 21'h000300 + 21'($urandom_range(0, 111));
        4:       cp = 21'h0000AD;
        default: cp = 21'($urandom_range(32'h80, 32'h7FF));
      endcase
      add_code(cp, 2);
    end else if (pick < 72) begin
      case ($urandom_range(0, 6))
        0:       cp = 21'h00FF01 + 21'($urandom_range(0, 93));
        1:       cp = zero_width_codes[$urandom_range(0, 5)];
        2:       cp = 21'h0020D0 + 21'($urandom_range(0, 47));
        3:       cp = 21'h001AB0 + 21'($urandom_range(0, 79));
        4:       cp = 21'h001DC0 + 21'($urandom_range(0, 63));
        5:       cp = 21'h00FE20 + 21'($urandom_range(0, 15));
        default: cp = 21'($urandom_range(32'h800, 32'hFFFF));
      endcase
      add_code(cp, 3);
    end else if (pick < 78) begin
      if ($urandom_range(0, 1) == 1) cp = 21'($urandom_range(32'h10000, 32'h10FFFF));
      else cp = 21'($urandom_range(32'h110000, 32'h1FFFFF));
      add_code(cp, 4);
    end else if (pick < 84) begin
      // overlong form of a smaller code point
      w = $urandom_range(2, 4);
      if (w == 2) cp = 21'($urandom_range(0, 32'h7F));
      else if (w == 3) cp = 21'($urandom_range(0, 32'h7FF));
      else cp = 21'($urandom_range(0, 32'hFFFF));
      add_code(cp, w);
    end else if (pick < 92) begin
      // sequence cut short, broken by whatever follows
      w = $urandom_range(2, 4);
      if (w == 2) cp = 21'($urandom_range(32'h80, 32'h7FF));
      else if (w == 3) cp = 21'($urandom_range(32'h800, 32'hFFFF));
      else cp = 21'($urandom_range(32'h10000, 32'h10FFFF));
      add_code(cp, w);
      keep = $urandom_range(1, w - 1);
      repeat (w - keep) void'(message_bytes.pop_back());
    end else begin
      append_byte(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    int n_tokens;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    repeat (2) @(negedge clk);
    foreach (DIRECTED_SEQ[i]) offer_byte(DIRECTED_SEQ[i][7:0], DIRECTED_SEQ[i][8]);
    bulk_phase = 1'b1;
    while (requests_sent < DIRECTED_COUNT + RANDOM_TARGET) begin
      message_bytes.delete();
      n_tokens = $urandom_range(1, 10);
      repeat (n_tokens) add_token();
      foreach (message_bytes[i]) offer_byte(message_bytes[i], i == message_bytes.size() - 1);
    end
    in_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (30) @(negedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
